>>> rtl/jdc_pkg.sv
package jdc_pkg;

	localparam int unsigned ONE_Q14 = 16384;

	typedef enum logic [2:0] {
		DIR_NONE  = 3'd0,
		DIR_RIGHT = 3'd1,
		DIR_LEFT  = 3'd2,
		DIR_UP    = 3'd3,
		DIR_DOWN  = 3'd4
	} dir_t;

	typedef enum logic [2:0] {
		REG_FULL_SCALE = 3'd0,
		REG_CENTER     = 3'd1,
		REG_TW_CBAND   = 3'd2,
		REG_TW_EBAND   = 3'd3,
		REG_INNER      = 3'd4,
		REG_OUTER      = 3'd5,
		REG_ENGAGE     = 3'd6,
		REG_RELEASE    = 3'd7
	} reg_idx_t;

	typedef struct packed {
		logic [11:0] full_scale_mv;
		logic [11:0] center_mv;
		logic [10:0] twist_center_band_mv;
		logic [10:0] twist_end_band_mv;
		logic [14:0] inner_radius;
		logic [14:0] outer_band;
		logic [14:0] engage_level;
		logic [14:0] release_level;
	} cfg_t;

	// shared divider: quotient = round(num / den), numerator up to 60 bits
	localparam int unsigned NUM_W = 60;
	localparam int unsigned DEN_W = 32;

	typedef struct packed {
		logic             start;
		logic [NUM_W-1:0] num;
		logic [DEN_W-1:0] den;
	} div_req_t;

	typedef struct packed {
		logic             done;
		logic [NUM_W-1:0] quo;
	} div_rsp_t;

endpackage

>>> rtl/jdc_div.sv
module jdc_div (
	input  logic              clk,
	input  logic              arst_n,
	input  jdc_pkg::div_req_t req,
	output jdc_pkg::div_rsp_t rsp
);
	import jdc_pkg::*;

	localparam int unsigned CW = $clog2(NUM_W + 2);

	// rounded quotient: (2n + d) / (2d), one bit a cycle
	logic [NUM_W+1:0] n_q;
	logic [NUM_W+1:0] quo_q;
	logic [DEN_W+NUM_W+1:0] rem_q;
	logic [DEN_W:0] d_q;
	logic [CW-1:0] cnt_q;
	logic busy_q;
	logic done_q;
	logic [DEN_W+NUM_W+1:0] shl;

	always_comb begin
		shl = {rem_q[DEN_W+NUM_W:0], n_q[NUM_W+1]};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= CW'(NUM_W + 2);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CW'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			n_q   <= {req.num, 1'b0} + {{(NUM_W+2-DEN_W){1'b0}}, req.den};
			d_q   <= {req.den, 1'b0};
			rem_q <= '0;
			quo_q <= '0;
		end else if (busy_q) begin
			n_q <= {n_q[NUM_W:0], 1'b0};
			if (shl >= {{(NUM_W+1){1'b0}}, d_q}) begin
				rem_q <= shl - {{(NUM_W+1){1'b0}}, d_q};
				quo_q <= {quo_q[NUM_W:0], 1'b1};
			end else begin
				rem_q <= shl;
				quo_q <= {quo_q[NUM_W:0], 1'b0};
			end
		end
	end

	assign rsp.done = done_q;
	assign rsp.quo  = quo_q[NUM_W-1:0];

endmodule

>>> rtl/jdc_sqrt.sv
module jdc_sqrt (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic [29:0] v,
	output logic        done,
	output logic [15:0] root
);
	// bit-pair restoring root, then round to nearest
	logic [29:0] v_q;
	logic [31:0] rem_q;
	logic [15:0] r_q;
	logic [3:0]  cnt_q;
	logic        busy_q;
	logic        fix_q;
	logic        done_q;
	logic [31:0] trial;
	logic [31:0] rem_sh;

	always_comb begin
		rem_sh = {rem_q[29:0], v_q[29:28]};
		trial  = {14'd0, r_q, 2'b01};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			fix_q  <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= 4'd14;
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == 4'd0) begin
					busy_q <= 1'b0;
					fix_q  <= 1'b1;
				end
			end else if (fix_q) begin
				fix_q  <= 1'b0;
				done_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			v_q   <= v;
			rem_q <= '0;
			r_q   <= '0;
		end else if (busy_q) begin
			v_q <= {v_q[27:0], 2'b00};
			if (rem_sh >= trial) begin
				rem_q <= rem_sh - trial;
				r_q   <= {r_q[14:0], 1'b1};
			end else begin
				rem_q <= rem_sh;
				r_q   <= {r_q[14:0], 1'b0};
			end
		end else if (fix_q) begin
			// v_q was shifted out; rem holds v - r*r
			if (rem_q > 32'(r_q)) r_q <= r_q + 1'b1;
		end
	end

	assign done = done_q;
	assign root = r_q;

endmodule

>>> rtl/jdc_seq.sv
module jdc_seq (
	input  logic              clk,
	input  logic              arst_n,
	input  jdc_pkg::cfg_t     cfg,
	input  logic              start,
	input  logic [11:0]       x_mv,
	input  logic [11:0]       y_mv,
	input  logic [11:0]       twist_mv,
	output jdc_pkg::div_req_t div_req,
	input  jdc_pkg::div_rsp_t div_rsp,
	output logic              sq_start,
	output logic [29:0]       sq_v,
	input  logic              sq_done,
	input  logic [15:0]       sq_root,
	output logic              done,
	output logic signed [15:0] x_o,
	output logic signed [15:0] y_o,
	output logic signed [15:0] z_o
);
	import jdc_pkg::*;

	typedef enum logic [9:0] {
		S_IDLE = 10'b0000000001,
		S_AX   = 10'b0000000010,
		S_AXW  = 10'b0000000100,
		S_MAG  = 10'b0000001000,
		S_MAGW = 10'b0000010000,
		S_DEN  = 10'b0000100000,
		S_RS   = 10'b0001000000,
		S_RSW  = 10'b0010000000,
		S_FIN  = 10'b0100000000,
		S_DONE = 10'b1000000000
	} st_t;

	st_t st_q;
	logic [1:0] ax_q;
	logic [11:0] raw_q [3];
	logic [14:0] mag_q [3];
	logic neg_q [3];
	logic [15:0] m_q;
	logic [NUM_W-1:0] num_q;
	logic [DEN_W-1:0] den_q;

	// axis setup, signed 14 bit differences
	logic signed [13:0] c, cb, eb, fs, hi, lo, span, rr, diff;
	logic go_div, neg_a;
	logic signed [16:0] thr, band;
	logic [29:0] sumsq;
	logic zero_c;

	always_comb begin
		c  = 14'(cfg.center_mv);
		fs = 14'(cfg.full_scale_mv);
		rr = 14'(raw_q[ax_q]);
		cb = (ax_q == 2'd2) ? 14'(cfg.twist_center_band_mv) : 14'sd0;
		eb = (ax_q == 2'd2) ? 14'(cfg.twist_end_band_mv) : 14'sd0;
		hi = c + cb;
		lo = c - cb;
		go_div = 1'b0;
		neg_a  = 1'b0;
		span   = '0;
		diff   = '0;
		if (rr > hi) begin
			span = (fs - eb) - hi;
			diff = rr - hi;
			go_div = span > 0;
		end else if (rr < lo) begin
			span = lo - eb;
			diff = lo - rr;
			go_div = span > 0;
			neg_a = 1'b1;
		end
		thr   = 17'sd16384 - $signed({2'b0, cfg.outer_band});
		band  = thr - $signed({2'b0, cfg.inner_radius});
		sumsq = 30'(mag_q[0]) * 30'(mag_q[0]) + 30'(mag_q[1]) * 30'(mag_q[1]);
		zero_c = (m_q == 16'd0) || ({1'b0, m_q} < {2'b0, cfg.inner_radius})
			|| (($signed({1'b0, m_q}) < thr) && (band <= 0));
	end

	logic [14:0] sat;
	always_comb begin
		sat = (div_rsp.quo > NUM_W'(ONE_Q14)) ? 15'(ONE_Q14) : div_rsp.quo[14:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= S_IDLE;
			ax_q <= '0;
		end else begin
			unique case (st_q)
				S_IDLE: if (start) begin
					st_q <= S_AX;
					ax_q <= '0;
				end
				S_AX: st_q <= go_div ? S_AXW : (ax_q == 2'd2 ? S_MAG : S_AX);
				S_AXW: if (div_rsp.done) st_q <= (ax_q == 2'd2) ? S_MAG : S_AX;
				S_MAG: st_q <= S_MAGW;
				S_MAGW: if (sq_done) st_q <= S_DEN;
				S_DEN: st_q <= zero_c ? S_FIN : S_RS;
				S_RS: st_q <= S_RSW;
				S_RSW: if (div_rsp.done) st_q <= (ax_q == 2'd1) ? S_FIN : S_RS;
				S_FIN: st_q <= S_DONE;
				S_DONE: st_q <= S_IDLE;
				default: st_q <= S_IDLE;
			endcase
			if (st_q == S_AX && !go_div && ax_q != 2'd2) ax_q <= ax_q + 1'b1;
			if (st_q == S_AXW && div_rsp.done && ax_q != 2'd2) ax_q <= ax_q + 1'b1;
			if (st_q == S_DEN) ax_q <= '0;
			if (st_q == S_RSW && div_rsp.done) ax_q <= ax_q + 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (st_q == S_IDLE && start) begin
			raw_q[0] <= x_mv;
			raw_q[1] <= y_mv;
			raw_q[2] <= twist_mv;
		end
		if (st_q == S_AX) begin
			mag_q[ax_q] <= '0;
			// y inverted
			neg_q[ax_q] <= neg_a ^ (ax_q == 2'd1);
			num_q <= NUM_W'(diff) << 14;
			den_q <= DEN_W'(span);
		end
		if ((st_q == S_AXW || st_q == S_RSW) && div_rsp.done) mag_q[ax_q] <= sat;
		if (st_q == S_MAGW && sq_done) m_q <= sq_root;
		if (st_q == S_DEN) begin
			if (zero_c) begin
				mag_q[0] <= '0;
				mag_q[1] <= '0;
			end else if ($signed({1'b0, m_q}) >= thr) begin
				num_q <= NUM_W'(ONE_Q14);
				den_q <= DEN_W'(m_q);
			end else begin
				num_q <= NUM_W'(17'(m_q) - 17'(cfg.inner_radius)) << 14;
				den_q <= DEN_W'(m_q) * DEN_W'(band[14:0]);
			end
		end
		if (st_q == S_RS) num_q <= num_q;
	end

	logic [NUM_W-1:0] rs_num;
	always_comb begin
		rs_num = (st_q == S_RS) ? NUM_W'(45'(mag_q[ax_q]) * 45'(num_q[29:0])) : num_q;
	end

	assign div_req.start = (st_q == S_AX && go_div) || st_q == S_RS;
	assign div_req.num   = (st_q == S_AX) ? NUM_W'(diff) << 14 : rs_num;
	assign div_req.den   = (st_q == S_AX) ? DEN_W'(span) : den_q;
	assign sq_start      = st_q == S_MAG;
	assign sq_v          = sumsq;
	assign done          = st_q == S_DONE;
	assign x_o = neg_q[0] ? -$signed({1'b0, mag_q[0]}) : $signed({1'b0, mag_q[0]});
	assign y_o = neg_q[1] ? -$signed({1'b0, mag_q[1]}) : $signed({1'b0, mag_q[1]});
	assign z_o = neg_q[2] ? -$signed({1'b0, mag_q[2]}) : $signed({1'b0, mag_q[2]});

endmodule

>>> rtl/joystick_deadzone_conditioner_top.sv
// channel | handshake            | payload
// cfg     | cfg_valid/cfg_ready  | cfg_index, cfg_data
// in      | in_valid/in_ready    | x_mv, y_mv, twist_mv, button_level
// out     | out_valid/out_ready  | x_pos, y_pos, twist_pos, direction, button_held, select_pulse
// one item runs from accept to result through up to three axis passes on the
// shared divider, a square root, and two rescale passes on the divider unless
// the center deadzone zeroes x and y
// reset clears the sequencer, engaged and button history, loads register defaults
// in_ready is low from accept until the result register is loaded, and while
// a result waits for out_ready
module joystick_deadzone_conditioner_top (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [2:0]  cfg_index,
	input  logic [14:0] cfg_data,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [11:0] x_mv,
	input  logic [11:0] y_mv,
	input  logic [11:0] twist_mv,
	input  logic        button_level,
	output logic        out_valid,
	input  logic        out_ready,
	output logic signed [15:0] x_pos,
	output logic signed [15:0] y_pos,
	output logic signed [15:0] twist_pos,
	output logic [2:0]  direction,
	output logic        button_held,
	output logic        select_pulse
);
	import jdc_pkg::*;

	cfg_t cfg_q;
	div_req_t div_req;
	div_rsp_t div_rsp;
	logic sq_start, sq_done, done, busy_q, btn_q, engaged_q, prev_q;
	logic [29:0] sq_v;
	logic [15:0] sq_root;
	logic signed [15:0] xo, yo, zo;
	logic [14:0] ax, ay, big;
	logic eng_n;
	dir_t dir;

	assign cfg_ready = 1'b1;
	assign in_ready  = !busy_q && (!out_valid || out_ready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '{12'd3300, 12'd1650, 11'd60, 11'd40, 15'd1638, 15'd819,
				15'd3277, 15'd1638};
		end else if (cfg_valid) begin
			unique case (reg_idx_t'(cfg_index))
				REG_FULL_SCALE: cfg_q.full_scale_mv        <= cfg_data[11:0];
				REG_CENTER:     cfg_q.center_mv            <= cfg_data[11:0];
				REG_TW_CBAND:   cfg_q.twist_center_band_mv <= cfg_data[10:0];
				REG_TW_EBAND:   cfg_q.twist_end_band_mv    <= cfg_data[10:0];
				REG_INNER:      cfg_q.inner_radius         <= cfg_data;
				REG_OUTER:      cfg_q.outer_band           <= cfg_data;
				REG_ENGAGE:     cfg_q.engage_level         <= cfg_data;
				REG_RELEASE:    cfg_q.release_level        <= cfg_data;
				default: ;
			endcase
		end
	end

	jdc_div u_div (.clk, .arst_n, .req(div_req), .rsp(div_rsp));
	jdc_sqrt u_sqrt (.clk, .arst_n, .start(sq_start), .v(sq_v), .done(sq_done),
		.root(sq_root));
	jdc_seq u_seq (
		.clk, .arst_n, .cfg(cfg_q), .start(in_valid && in_ready),
		.x_mv, .y_mv, .twist_mv, .div_req, .div_rsp, .sq_start, .sq_v, .sq_done,
		.sq_root, .done, .x_o(xo), .y_o(yo), .z_o(zo)
	);

	always_comb begin
		ax  = xo[15] ? 15'(-xo) : xo[14:0];
		ay  = yo[15] ? 15'(-yo) : yo[14:0];
		big = (ax > ay) ? ax : ay;
		if (big > cfg_q.engage_level) eng_n = 1'b1;
		else if (big < cfg_q.release_level) eng_n = 1'b0;
		else eng_n = engaged_q;
		dir = DIR_NONE;
		if (eng_n) begin
			if (ax >= ay) dir = (xo > 0) ? DIR_RIGHT : DIR_LEFT;
			else dir = (yo > 0) ? DIR_UP : DIR_DOWN;
		end
	end

	// input waits for a free output register, so a finishing item always has one
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q    <= 1'b0;
			out_valid <= 1'b0;
			engaged_q <= 1'b0;
			prev_q    <= 1'b0;
		end else begin
			if (out_valid && out_ready) out_valid <= 1'b0;
			if (in_valid && in_ready) busy_q <= 1'b1;
			if (done) begin
				busy_q    <= 1'b0;
				out_valid <= 1'b1;
				engaged_q <= eng_n;
				prev_q    <= btn_q;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) btn_q <= button_level;
		if (done) begin
			x_pos        <= xo;
			y_pos        <= yo;
			twist_pos    <= zo;
			direction    <= dir;
			button_held  <= btn_q;
			select_pulse <= btn_q && !prev_q;
		end
	end

endmodule

>>> rtl/jdc_check.sv
module jdc_check (
	input logic        clk,
	input logic        arst_n,
	input logic        in_valid,
	input logic        in_ready,
	input logic        out_valid,
	input logic        out_ready,
	input logic [2:0]  direction,
	input logic        button_held,
	input logic        select_pulse,
	input logic signed [15:0] x_pos
);
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(x_pos))
		else $error("result dropped while stalled");
	a_sel: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && select_pulse |-> button_held)
		else $error("select without button");
	a_dir: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> direction <= 3'd4)
		else $error("bad direction");
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("accepted while busy");
endmodule

bind joystick_deadzone_conditioner_top jdc_check u_chk (.*);

>>> test/jdc_checker.sv
`timescale 1ns / 100ps

module jdc_checker
	import jdc_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_valid,
	input  logic               cfg_ready,
	input  logic [2:0]         cfg_index,
	input  logic [14:0]        cfg_data,
	input  logic               in_valid,
	input  logic               in_ready,
	input  logic [11:0]        x_mv,
	input  logic [11:0]        y_mv,
	input  logic [11:0]        twist_mv,
	input  logic               button_level,
	input  logic               out_valid,
	input  logic               out_ready,
	input  logic signed [15:0] x_pos,
	input  logic signed [15:0] y_pos,
	input  logic signed [15:0] twist_pos,
	input  logic [2:0]         direction,
	input  logic               button_held,
	input  logic               select_pulse,
	output int                 errors,
	output int                 pending
);

	typedef struct {
		logic signed [15:0] x;
		logic signed [15:0] y;
		logic signed [15:0] twist;
		dir_t               dir;
		logic               held;
		logic               sel;
	} sample_t;

	cfg_t    cfg;
	logic    engaged;
	logic    btn_prev;
	sample_t sample_q[$];

	function automatic longint unsigned div_round(longint unsigned n, longint unsigned d);
		return (2 * n + d) / (2 * d);
	endfunction

	function automatic int clip_q14(longint unsigned mag, bit neg);
		int v;
		v = (mag > ONE_Q14) ? ONE_Q14 : int'(mag);
		return neg ? -v : v;
	endfunction

	function automatic int map_axis(int raw, int cband, int eband, bit inv);
		int c, hi, lo, span, o;
		c = int'(cfg.center_mv);
		hi = c + cband;
		lo = c - cband;
		o = 0;
		if (raw > hi) begin
			span = (int'(cfg.full_scale_mv) - eband) - hi;
			if (span > 0)
				o = clip_q14(div_round(longint'(raw - hi) * ONE_Q14, span), 0);
		end else if (raw < lo) begin
			span = lo - eband;
			if (span > 0)
				o = clip_q14(div_round(longint'(lo - raw) * ONE_Q14, span), 1);
		end
		return inv ? -o : o;
	endfunction

	function automatic longint unsigned root_round(longint unsigned v);
		longint unsigned rem, r, b;
		rem = v;
		r = 0;
		b = 64'd1 << 32;
		while (b > rem)
			b >>= 2;
		while (b != 0) begin
			if (rem >= r + b) begin
				rem -= r + b;
				r = (r >> 1) + b;
			end else begin
				r >>= 1;
			end
			b >>= 2;
		end
		if (v - r * r > r)
			r++;
		return r;
	endfunction

	function automatic int scale_axis(int v, longint unsigned num, longint unsigned den);
		longint unsigned a;
		a = (v < 0) ? -v : v;
		return clip_q14(div_round(a * num, den), v < 0);
	endfunction

	function automatic sample_t condition(int xr, int yr, int tr, logic btn);
		sample_t s;
		int x, y, z, inner, thr, band, ax, ay, big;
		longint unsigned m, num, den;
		x = map_axis(xr, 0, 0, 0);
		y = map_axis(yr, 0, 0, 1);
		z = map_axis(tr, int'(cfg.twist_center_band_mv), int'(cfg.twist_end_band_mv), 0);
		m = root_round(longint'(x) * x + longint'(y) * y);
		inner = int'(cfg.inner_radius);
		thr = ONE_Q14 - int'(cfg.outer_band);
		if (m == 0 || longint'(m) < inner) begin
			x = 0;
			y = 0;
		end else if (longint'(m) >= thr) begin
			x = scale_axis(x, ONE_Q14, m);
			y = scale_axis(y, ONE_Q14, m);
		end else begin
			band = thr - inner;
			if (band <= 0) begin
				x = 0;
				y = 0;
			end else begin
				num = (m - inner) * ONE_Q14;
				den = m * band;
				x = scale_axis(x, num, den);
				y = scale_axis(y, num, den);
			end
		end
		ax = (x < 0) ? -x : x;
		ay = (y < 0) ? -y : y;
		big = (ax > ay) ? ax : ay;
		if (big > int'(cfg.engage_level))
			engaged = 1;
		else if (big < int'(cfg.release_level))
			engaged = 0;
		s.dir = DIR_NONE;
		if (engaged) begin
			if (ax >= ay)
				s.dir = (x > 0) ? DIR_RIGHT : DIR_LEFT;
			else
				s.dir = (y > 0) ? DIR_UP : DIR_DOWN;
		end
		s.x = x;
		s.y = y;
		s.twist = z;
		s.held = btn;
		s.sel = btn && !btn_prev;
		btn_prev = btn;
		return s;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		sample_t e;
		if (!arst_n) begin
			cfg.full_scale_mv = 3300;
			cfg.center_mv = 1650;
			cfg.twist_center_band_mv = 60;
			cfg.twist_end_band_mv = 40;
			cfg.inner_radius = 1638;
			cfg.outer_band = 819;
			cfg.engage_level = 3277;
			cfg.release_level = 1638;
			engaged = 0;
			btn_prev = 0;
			errors = 0;
			sample_q.delete();
			pending = 0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				case (reg_idx_t'(cfg_index))
					REG_FULL_SCALE: cfg.full_scale_mv = cfg_data[11:0];
					REG_CENTER:     cfg.center_mv = cfg_data[11:0];
					REG_TW_CBAND:   cfg.twist_center_band_mv = cfg_data[10:0];
					REG_TW_EBAND:   cfg.twist_end_band_mv = cfg_data[10:0];
					REG_INNER:      cfg.inner_radius = cfg_data;
					REG_OUTER:      cfg.outer_band = cfg_data;
					REG_ENGAGE:     cfg.engage_level = cfg_data;
					REG_RELEASE:    cfg.release_level = cfg_data;
					default: ;
				endcase
			end
			if (out_valid && out_ready) begin
				if (sample_q.size() == 0) begin
					$error("result item with nothing expected");
					errors++;
				end else begin
					e = sample_q.pop_front();
					if (x_pos !== e.x) begin
						$error("x_pos expected %0d actual %0d", e.x, x_pos);
						errors++;
					end
					if (y_pos !== e.y) begin
						$error("y_pos expected %0d actual %0d", e.y, y_pos);
						errors++;
					end
					if (twist_pos !== e.twist) begin
						$error("twist_pos expected %0d actual %0d", e.twist, twist_pos);
						errors++;
					end
					if (direction !== e.dir) begin
						$error("direction expected %0d actual %0d", e.dir, direction);
						errors++;
					end
					if (button_held !== e.held) begin
						$error("button_held expected %0d actual %0d", e.held, button_held);
						errors++;
					end
					if (select_pulse !== e.sel) begin
						$error("select_pulse expected %0d actual %0d", e.sel, select_pulse);
						errors++;
					end
				end
			end
			if (in_valid && in_ready)
				sample_q.push_back(condition(x_mv, y_mv, twist_mv, button_level));
			pending = sample_q.size();
		end
	end

endmodule

>>> test/testbench.sv
`timescale 1ns / 100ps

module testbench;
	import jdc_pkg::*;

	localparam int CYCLE_LIMIT = 3000000;

	logic               clk;
	logic               arst_n;
	logic               cfg_valid;
	logic               cfg_ready;
	logic [2:0]         cfg_index;
	logic [14:0]        cfg_data;
	logic               in_valid;
	logic               in_ready;
	logic [11:0]        x_mv;
	logic [11:0]        y_mv;
	logic [11:0]        twist_mv;
	logic               button_level;
	logic               out_valid;
	logic               out_ready;
	logic signed [15:0] x_pos;
	logic signed [15:0] y_pos;
	logic signed [15:0] twist_pos;
	logic [2:0]         direction;
	logic               button_held;
	logic               select_pulse;
	int                 errors;
	int                 pending;

	int  send_idle;
	int  recv_idle;
	bit  long_stall_req;
	int  stall_left;
	int  cycles;
	int  center;

	joystick_deadzone_conditioner_top dut (.*);

	jdc_checker checker_i (.*);

	initial clk = 0;
	always #5 clk = ~clk;

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("joystick_deadzone_conditioner_top regression: fail");
			$finish;
		end
	end

	// receiver side
	always @(negedge clk) begin
		if (long_stall_req) begin
			long_stall_req = 0;
			stall_left = 3000;
		end
		if (stall_left > 0) begin
			stall_left--;
			out_ready <= 0;
		end else begin
			out_ready <= ($urandom_range(99) >= recv_idle);
		end
	end

	task automatic write_reg(reg_idx_t idx, int value);
		@(negedge clk);
		cfg_valid <= 1;
		cfg_index <= idx;
		cfg_data <= 15'(value);
		do @(posedge clk); while (!cfg_ready);
		@(negedge clk);
		cfg_valid <= 0;
	endtask

	task automatic put_sample(int x, int y, int t, bit b);
		@(negedge clk);
		while ($urandom_range(99) < send_idle) begin
			in_valid <= 0;
			@(negedge clk);
		end
		in_valid <= 1;
		x_mv <= 12'(x);
		y_mv <= 12'(y);
		twist_mv <= 12'(t);
		button_level <= b;
		do @(posedge clk); while (!in_ready);
	endtask

	task automatic drain;
		@(negedge clk);
		in_valid <= 0;
		while (pending != 0)
			@(posedge clk);
		repeat (400) @(posedge clk);
	endtask

	task automatic load_cfg(int fs, int c, int cb, int eb, int inr, int ob, int en, int rl);
		drain();
		write_reg(REG_FULL_SCALE, fs);
		write_reg(REG_CENTER, c);
		write_reg(REG_TW_CBAND, cb);
		write_reg(REG_TW_EBAND, eb);
		write_reg(REG_INNER, inr);
		write_reg(REG_OUTER, ob);
		write_reg(REG_ENGAGE, en);
		write_reg(REG_RELEASE, rl);
		center = c;
	endtask

	function automatic int pick_mv();
		int v;
		case ($urandom_range(3))
			0: v = $urandom_range(4095);
			1: v = center + $urandom_range(600) - 300;
			2: v = $urandom_range(1) ? $urandom_range(4095, 3900) : $urandom_range(200);
			default: v = center + $urandom_range(3000) - 1500;
		endcase
		if (v < 0)
			v = 0;
		if (v > 4095)
			v = 4095;
		return v;
	endfunction

	initial begin
		int lv[3];
		arst_n = 0;
		cfg_valid = 0;
		cfg_index = REG_FULL_SCALE;
		cfg_data = 0;
		in_valid = 0;
		x_mv = 0;
		y_mv = 0;
		twist_mv = 0;
		button_level = 0;
		out_ready = 0;
		send_idle = 10;
		recv_idle = 47;
		long_stall_req = 0;
		stall_left = 0;
		cycles = 0;
		center = 1650;
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n = 1;

		// rails, centre and button edges
		lv = '{0, 1650, 4095};
		for (int i = 0; i < 3; i++)
			for (int j = 0; j < 3; j++)
				put_sample(lv[i], lv[j], lv[(i + j) % 3], (i + j) % 2);
		put_sample(1650, 1650, 1650, 1);
		put_sample(1650, 1650, 1700, 1);
		put_sample(1650, 1650, 1600, 0);
		put_sample(3300, 1650, 3260, 1);
		put_sample(0, 3300, 40, 0);
		put_sample(1800, 1650, 1710, 1);
		put_sample(1700, 1650, 4095, 0);
		put_sample(2900, 2900, 0, 1);
		put_sample(2000, 1300, 1650, 0);
		put_sample(1700, 1700, 1650, 1);

		for (int p = 0; p < 6; p++) begin
			case (p)
				0: ;
				1: load_cfg(1, 0, 2047, 2047, 0, 0, 0, 16384);
				2: load_cfg(4095, 4095, 0, 0, 16384, 16384, 16384, 0);
				3: load_cfg(4095, 2048, 0, 0, 0, 0, 16384, 16384);
				default: load_cfg($urandom_range(4095, 1), $urandom_range(4095),
					$urandom_range(2047), $urandom_range(2047), $urandom_range(16384),
					$urandom_range(16384), $urandom_range(16384), $urandom_range(16384));
			endcase
			if (p == 2 || p == 3) begin
				send_idle = 47;
				recv_idle = 10;
			end else if (p >= 4) begin
				send_idle = 0;
				recv_idle = 0;
			end
			for (int k = 0; k < 280; k++) begin
				if (p == 1 && k == 20)
					long_stall_req = 1;
				put_sample(pick_mv(), pick_mv(), pick_mv(), $urandom_range(1));
			end
		end
		drain();

		if (errors == 0)
			$display("joystick_deadzone_conditioner_top regression: pass");
		else
			$display("joystick_deadzone_conditioner_top regression: fail");
		$finish;
	end

endmodule
